@@ design/twstm_pkg.sv @@
package twstm_pkg;

	// Transaction stage codes.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_CMD   = 3'd1,
		ST_WDATA = 3'd2,
		ST_RDATA = 3'd3,
		ST_END   = 3'd4
	} stage_t;

	// Request codes on the command field.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// A sampled IO bit enters the shift register at its top.
	localparam logic [7:0] SAMPLE_TOP = 8'h80;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] address;
		logic [7:0] write_data;
		logic [4:0] burst_count;
		logic       io_in;
	} in_word_t;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       io_out;
		logic       io_drive;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       last_byte;
		logic       busy_res;
	} out_word_t;

endpackage

@@ design/three_wire_serial_transaction_master.sv @@
// Master for a three-wire serial bus (CE, SCLK, IO). Every input word is one
// tick of the bus and yields exactly one output word carrying the pin levels
// for that tick plus any read byte completed on it. A read or write request,
// taken only while idle, raises CE for one tick, then shifts the command byte
// out least significant bit first with bit 0 forced to 1 for a read and 0 for
// a write; each bit is a data tick followed by a clock-high tick. A write then
// sends one data byte the same way; a read releases IO and clocks in 1 to 31
// bytes (a burst count of zero reads one byte, and counts above MAX_BURST are
// clipped to it), each bit taking a clock-high and a clock-low tick, with IO
// sampled on the following tick. A last tick drops CE and flags the final
// read byte with last_byte. Throughput is one word per clock: the sequencer
// state and the next pin levels are computed combinationally straight into
// the result register, and input is held off only while that register holds
// a word the consumer has not taken.
module three_wire_serial_transaction_master #(
	parameter int MAX_BURST = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  twstm_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output twstm_pkg::out_word_t out_data
);

	logic                 step;
	twstm_pkg::out_word_t result;

	// The sequencer advances on every accepted word.
	assign step = in_valid && in_ready;

	twstm_core #(
		.MAX_BURST(MAX_BURST)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.in_word(in_data),
		.result (result)
	);

	twstm_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.result   (result),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

@@ design/twstm_core.sv @@
// Bus sequencer: holds the transaction state and works out the pin levels and
// read results for one tick from that state and the incoming word.
module twstm_core #(
	parameter int MAX_BURST = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  twstm_pkg::in_word_t  in_word,
	output twstm_pkg::out_word_t result
);

	twstm_pkg::stage_t stage_q, stage_n;
	logic       reading_q, reading_n;
	logic [2:0] bit_pos_q, bit_pos_n;
	logic       half_q, half_n;
	logic [7:0] shifter_q, shifter_n;
	logic [7:0] held_wr_q, held_wr_n;
	logic [4:0] remain_q, remain_n;
	logic       pending_q, pending_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= twstm_pkg::ST_IDLE;
			reading_q <= 1'b0;
			bit_pos_q <= 3'd0;
			half_q    <= 1'b0;
			shifter_q <= 8'd0;
			held_wr_q <= 8'd0;
			remain_q  <= 5'd0;
			pending_q <= 1'b0;
		end else if (step) begin
			stage_q   <= stage_n;
			reading_q <= reading_n;
			bit_pos_q <= bit_pos_n;
			half_q    <= half_n;
			shifter_q <= shifter_n;
			held_wr_q <= held_wr_n;
			remain_q  <= remain_n;
			pending_q <= pending_n;
		end
	end

	always_comb begin
		logic [4:0] cnt;
		logic       sample;
		logic [7:0] sh_sampled;
		logic [2:0] bp_sampled;

		stage_n   = stage_q;
		reading_n = reading_q;
		bit_pos_n = bit_pos_q;
		half_n    = half_q;
		shifter_n = shifter_q;
		held_wr_n = held_wr_q;
		remain_n  = remain_q;
		pending_n = pending_q;

		result              = '0;
		result.io_drive     = 1'b1;

		cnt    = in_word.burst_count;
		sample = 1'b0;

		// Shared sampling step: shift the IO level in at the top.
		sh_sampled = (shifter_q >> 1) | (in_word.io_in ? twstm_pkg::SAMPLE_TOP : 8'd0);
		bp_sampled = bit_pos_q + 3'd1;

		case (stage_q)
			twstm_pkg::ST_CMD, twstm_pkg::ST_WDATA: begin
				result.chip_enable = 1'b1;
				result.busy_res    = 1'b1;
				result.io_out      = shifter_q[0];
				if (!half_q) begin
					half_n = 1'b1;
				end else begin
					result.serial_clock = 1'b1;
					half_n    = 1'b0;
					shifter_n = shifter_q >> 1;
					bit_pos_n = bp_sampled;
					if (bp_sampled == 3'd0) begin
						if (stage_q == twstm_pkg::ST_CMD) begin
							if (reading_q) begin
								stage_n   = twstm_pkg::ST_RDATA;
								shifter_n = 8'd0;
							end else begin
								stage_n   = twstm_pkg::ST_WDATA;
								shifter_n = held_wr_q;
							end
						end else begin
							stage_n = twstm_pkg::ST_END;
						end
					end
				end
			end
			twstm_pkg::ST_RDATA: begin
				result.chip_enable = 1'b1;
				result.busy_res    = 1'b1;
				result.io_drive    = 1'b0;
				if (!half_q) begin
					sample              = pending_q;
					result.serial_clock = 1'b1;
					half_n              = 1'b1;
				end else begin
					half_n    = 1'b0;
					pending_n = 1'b1;
					if (bit_pos_q == 3'd7 && remain_q <= 5'd1)
						stage_n = twstm_pkg::ST_END;
				end
			end
			twstm_pkg::ST_END: begin
				result.busy_res = 1'b1;
				sample          = pending_q;
			end
			default: begin
				stage_n = twstm_pkg::ST_IDLE;
				if (in_word.command == twstm_pkg::CMD_READ ||
				    in_word.command == twstm_pkg::CMD_WRITE) begin
					reading_n = (in_word.command == twstm_pkg::CMD_READ);
					shifter_n = reading_n ? (in_word.address | 8'h01)
					                      : (in_word.address & 8'hFE);
					held_wr_n = in_word.write_data;
					if (cnt == 5'd0)
						cnt = 5'd1;
					if ({3'd0, cnt} > 8'(MAX_BURST))
						cnt = 5'(MAX_BURST);
					remain_n  = cnt;
					bit_pos_n = 3'd0;
					half_n    = 1'b0;
					pending_n = 1'b0;
					stage_n   = twstm_pkg::ST_CMD;
					result.chip_enable = 1'b1;
					result.busy_res    = 1'b1;
				end
			end
		endcase

		if (sample) begin
			shifter_n = sh_sampled;
			bit_pos_n = bp_sampled;
			pending_n = 1'b0;
			if (bp_sampled == 3'd0) begin
				result.read_byte  = sh_sampled;
				result.read_valid = 1'b1;
				shifter_n         = 8'd0;
				if (remain_q != 5'd0)
					remain_n = remain_q - 5'd1;
			end
		end

		// The CE-low tick closes the transaction whatever was sampled.
		if (stage_q == twstm_pkg::ST_END) begin
			result.last_byte = result.read_valid;
			if (pending_q)
				remain_n = 5'd0;
			pending_n = 1'b0;
			half_n    = 1'b0;
			bit_pos_n = 3'd0;
			stage_n   = twstm_pkg::ST_IDLE;
		end
	end

endmodule

@@ design/twstm_out_reg.sv @@
// Result register. A new word is taken whenever the register is empty or its
// word leaves in the same cycle.
module twstm_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  twstm_pkg::out_word_t result,
	output logic                 out_valid,
	input  logic                 out_ready,
	output twstm_pkg::out_word_t out_data
);

	logic                 valid_q;
	twstm_pkg::out_word_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= result;
		end
	end

endmodule

@@ sim/tb_three_wire_serial_transaction_master.sv @@
`timescale 1ns / 100ps

module tb_three_wire_serial_transaction_master;

	localparam int BURST_CAP = 31;
	localparam int HALF_PERIOD = 4;
	localparam int RANDOM_TICKS = 560;
	localparam int CYCLE_LIMIT = 100000;
	// The package defines no request for this code; the master must treat it as a plain tick.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Cycles in which neither side inserts random bubbles.
	localparam int QUIET_FROM = 600;
	localparam int QUIET_TO = 1000;
	// The output side stops taking words for a long stretch once this many have come.
	localparam int HOLD_AT_WORD = 150;
	localparam int HOLD_CYCLES = 300;

	typedef enum {IO_LOW, IO_HIGH, IO_RANDOM} io_fill_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	twstm_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	twstm_pkg::out_word_t out_data;

	// Bus ticks waiting to be offered, and the pin words they are predicted to produce.
	twstm_pkg::in_word_t tick_words_q[$];
	twstm_pkg::out_word_t pin_words_q[$];

	int cycle_count = 0;
	int bad_fields = 0;
	int words_taken = 0;
	int hold_left = 0;

	// Private copy of the sequencer state that the prediction walks through.
	twstm_pkg::stage_t seq_stage;
	logic seq_is_read;
	logic [2:0] seq_bit;
	logic seq_half;
	logic [7:0] seq_shift;
	logic [7:0] seq_wbyte;
	logic [4:0] seq_bytes_left;
	logic seq_sample_due;

	three_wire_serial_transaction_master #(
		.MAX_BURST(BURST_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic logic quiet_now();
		return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
	endfunction

	function automatic void clear_sequencer();
		seq_stage = twstm_pkg::ST_IDLE;
		seq_is_read = 1'b0;
		seq_bit = '0;
		seq_half = 1'b0;
		seq_shift = '0;
		seq_wbyte = '0;
		seq_bytes_left = '0;
		seq_sample_due = 1'b0;
	endfunction

	// Shifts one sampled IO bit in at the top. When the eighth bit lands, the
	// assembled byte is handed out and one byte is taken off the burst.
	function automatic void capture_bit(input logic io, output logic [7:0] got_byte,
			output logic got_valid);
		got_byte = '0;
		got_valid = 1'b0;
		seq_shift = (seq_shift >> 1) | (io ? twstm_pkg::SAMPLE_TOP : 8'h00);
		seq_bit = seq_bit + 3'd1;
		seq_sample_due = 1'b0;
		if (seq_bit == 3'd0) begin
			got_byte = seq_shift;
			got_valid = 1'b1;
			if (seq_bytes_left != 5'd0)
				seq_bytes_left = seq_bytes_left - 5'd1;
			seq_shift = '0;
		end
	endfunction

	// One bus tick: advances the private sequencer and returns the pin word.
	function automatic twstm_pkg::out_word_t bus_tick(twstm_pkg::in_word_t w);
		twstm_pkg::out_word_t r;
		logic [4:0] n;
		r = '0;
		// The bus rests driven low unless the read phase releases it.
		r.io_drive = 1'b1;
		case (seq_stage)
		twstm_pkg::ST_CMD, twstm_pkg::ST_WDATA: begin
			r.chip_enable = 1'b1;
			r.busy_res = 1'b1;
			r.io_out = seq_shift[0];
			if (!seq_half) begin
				seq_half = 1'b1;
			end else begin
				r.serial_clock = 1'b1;
				seq_half = 1'b0;
				seq_shift = seq_shift >> 1;
				seq_bit = seq_bit + 3'd1;
				if (seq_bit == 3'd0) begin
					if (seq_stage == twstm_pkg::ST_CMD) begin
						if (seq_is_read) begin
							seq_stage = twstm_pkg::ST_RDATA;
							seq_shift = '0;
						end else begin
							seq_stage = twstm_pkg::ST_WDATA;
							seq_shift = seq_wbyte;
						end
					end else begin
						seq_stage = twstm_pkg::ST_END;
					end
				end
			end
		end
		twstm_pkg::ST_RDATA: begin
			r.chip_enable = 1'b1;
			r.busy_res = 1'b1;
			r.io_drive = 1'b0;
			if (!seq_half) begin
				if (seq_sample_due)
					capture_bit(w.io_in, r.read_byte, r.read_valid);
				r.serial_clock = 1'b1;
				seq_half = 1'b1;
			end else begin
				seq_half = 1'b0;
				seq_sample_due = 1'b1;
				if (seq_bit == 3'd7 && seq_bytes_left <= 5'd1)
					seq_stage = twstm_pkg::ST_END;
			end
		end
		twstm_pkg::ST_END: begin
			// CE drops; in a read this tick still samples the final bit.
			r.busy_res = 1'b1;
			if (seq_sample_due) begin
				capture_bit(w.io_in, r.read_byte, r.read_valid);
				r.last_byte = r.read_valid;
				seq_bytes_left = '0;
			end
			seq_sample_due = 1'b0;
			seq_half = 1'b0;
			seq_bit = '0;
			seq_stage = twstm_pkg::ST_IDLE;
		end
		default: begin
			seq_stage = twstm_pkg::ST_IDLE;
			if (w.command == twstm_pkg::CMD_READ || w.command == twstm_pkg::CMD_WRITE) begin
				seq_is_read = (w.command == twstm_pkg::CMD_READ);
				seq_shift = seq_is_read ? (w.address | 8'h01) : (w.address & 8'hFE);
				seq_wbyte = w.write_data;
				n = (w.burst_count == 5'd0) ? 5'd1 : w.burst_count;
				if (n > BURST_CAP)
					n = 5'(BURST_CAP);
				seq_bytes_left = n;
				seq_bit = '0;
				seq_half = 1'b0;
				seq_sample_due = 1'b0;
				seq_stage = twstm_pkg::ST_CMD;
				r.chip_enable = 1'b1;
				r.busy_res = 1'b1;
			end
		end
		endcase
		return r;
	endfunction

	function automatic logic pick_io(io_fill_t fill);
		case (fill)
		IO_LOW: return 1'b0;
		IO_HIGH: return 1'b1;
		default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// Queues a single word built from the given field values.
	task automatic add_word(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data,
			logic [4:0] cnt, logic io);
		twstm_pkg::in_word_t w;
		w.command = cmd;
		w.address = addr;
		w.write_data = data;
		w.burst_count = cnt;
		w.io_in = io;
		tick_words_q.push_back(w);
	endtask

	task automatic add_idle(int ticks);
		for (int i = 0; i < ticks; i++) begin
			add_word($urandom_range(0, 1) ? twstm_pkg::CMD_TICK : CMD_UNUSED,
				8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom_range(0, 1)));
		end
	endtask

	// Queues a request followed by exactly as many ticks as the transaction runs.
	// Those ticks carry random commands, which the block must ignore while busy.
	task automatic add_transaction(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data,
			logic [4:0] cnt, io_fill_t fill);
		int span;
		int bytes;
		bytes = (cnt == 5'd0) ? 1 : ((cnt > BURST_CAP) ? BURST_CAP : cnt);
		// Request tick, 16 command ticks, 16 ticks per data byte, CE-low tick.
		span = (cmd == twstm_pkg::CMD_READ) ? 18 + 16 * bytes : 34;
		add_word(cmd, addr, data, cnt, pick_io(fill));
		for (int i = 1; i < span; i++) begin
			add_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
				5'($urandom), pick_io(fill));
		end
	endtask

	function automatic logic [4:0] pick_burst();
		int roll;
		roll = $urandom_range(0, 99);
		// Short bursts keep the run brisk; long ones appear now and then.
		if (roll < 85)
			return 5'($urandom_range(0, 3));
		else if (roll < 97)
			return 5'($urandom_range(4, 8));
		else
			return 5'($urandom_range(0, 31));
	endfunction

	task automatic report(string field, int want, int got);
		$display("%0t: %s expected %0h, got %0h", $realtime, field, want, got);
		bad_fields++;
	endtask

	task automatic check_word(twstm_pkg::out_word_t want, twstm_pkg::out_word_t got);
		if (want.chip_enable !== got.chip_enable)
			report("chip_enable", want.chip_enable, got.chip_enable);
		if (want.serial_clock !== got.serial_clock)
			report("serial_clock", want.serial_clock, got.serial_clock);
		if (want.io_out !== got.io_out)
			report("io_out", want.io_out, got.io_out);
		if (want.io_drive !== got.io_drive)
			report("io_drive", want.io_drive, got.io_drive);
		if (want.read_byte !== got.read_byte)
			report("read_byte", want.read_byte, got.read_byte);
		if (want.read_valid !== got.read_valid)
			report("read_valid", want.read_valid, got.read_valid);
		if (want.last_byte !== got.last_byte)
			report("last_byte", want.last_byte, got.last_byte);
		if (want.busy_res !== got.busy_res)
			report("busy_res", want.busy_res, got.busy_res);
	endtask

	// Input side. A word offered stays put until the block takes it; each taken
	// word is run through the prediction right away, so the expected pin words
	// line up in the order the block has to produce them. Between words the
	// sender sometimes leaves a bubble, except inside the quiet window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			clear_sequencer();
		end else begin
			if (in_valid && in_ready)
				pin_words_q.push_back(bus_tick(in_data));
			if (!in_valid || in_ready) begin
				if (tick_words_q.size() != 0 &&
						(quiet_now() || $urandom_range(0, 99) >= 14)) begin
					in_data <= tick_words_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side. Every word taken is checked against the oldest prediction.
	// Once, the consumer stops taking words for a long while so that the result
	// register stays full and the block has to push back on its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pin_words_q.size() == 0) begin
					$display("%0t: output word %h arrived with no prediction waiting",
						$realtime, out_data);
					bad_fields++;
				end else begin
					check_word(pin_words_q.pop_front(), out_data);
				end
				words_taken++;
				if (words_taken == HOLD_AT_WORD)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet_now() || $urandom_range(0, 99) >= 14;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int random_start;
		// Plain ticks, including the code that means nothing, with the bus idle.
		add_word(twstm_pkg::CMD_TICK, 8'h00, 8'h00, 5'd0, 1'b0);
		add_word(CMD_UNUSED, 8'hFF, 8'hFF, 5'd31, 1'b1);
		// Writes at the extremes of address and data; bit 0 of the command
		// byte must come out low whatever the address says.
		add_transaction(twstm_pkg::CMD_WRITE, 8'hFF, 8'h00, 5'd0, IO_RANDOM);
		add_transaction(twstm_pkg::CMD_WRITE, 8'h00, 8'hFF, 5'd31, IO_RANDOM);
		add_idle(2);
		// Reads: a zero burst reads one byte, and bit 0 of the command byte is
		// forced high. All-ones and all-zeros lines give every bit of a byte the same level.
		add_transaction(twstm_pkg::CMD_READ, 8'h00, 8'h5A, 5'd0, IO_HIGH);
		add_transaction(twstm_pkg::CMD_READ, 8'hFE, 8'hA5, 5'd1, IO_LOW);
		add_transaction(twstm_pkg::CMD_READ, 8'hAA, 8'h00, 5'd2, IO_RANDOM);
		add_idle(1);
		// The longest burst the field allows.
		add_transaction(twstm_pkg::CMD_READ, 8'h55, 8'hFF, 5'd31, IO_RANDOM);
		add_transaction(twstm_pkg::CMD_WRITE, 8'h81, 8'h7E, 5'd3, IO_HIGH);
		add_idle(3);

		// Random part: mostly complete transactions with random content, back to
		// back or with short idle gaps, plus some stretches of pure noise.
		random_start = tick_words_q.size();
		while (tick_words_q.size() - random_start < RANDOM_TICKS) begin
			case ($urandom_range(0, 9))
			0: add_idle($urandom_range(1, 12));
			1, 2, 3, 4, 5: add_transaction(twstm_pkg::CMD_READ, 8'($urandom),
				8'($urandom), pick_burst(), IO_RANDOM);
			default: add_transaction(twstm_pkg::CMD_WRITE, 8'($urandom), 8'($urandom),
				5'($urandom), IO_RANDOM);
			endcase
			add_idle($urandom_range(0, 3));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (tick_words_q.size() != 0 || in_valid || pin_words_q.size() != 0)
			@(posedge clk);
		// Anything the block still emits now has no prediction and is flagged.
		repeat (20) @(posedge clk);
		if (bad_fields == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("%0t: run did not finish in %0d cycles", $realtime, CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
